[hw/rtl/stake_weighted_vote_tally_defines.svh]
// Assertion macros used by the vote tally top level.
`ifndef STAKE_WEIGHTED_VOTE_TALLY_DEFINES_SVH
`define STAKE_WEIGHTED_VOTE_TALLY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SWVT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SWVT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/swvt_pkg.sv]
// Package with the types, constants and codes of the vote tally.
`default_nettype none

package swvt_pkg;

	// Table sizes.
	localparam int VALIDATORS = 1024;
	localparam int SLOTS      = 64;

	localparam int VAL_AW  = (VALIDATORS > 1) ? $clog2(VALIDATORS) : 1;
	localparam int VAL_CW  = $clog2(VALIDATORS + 1);
	localparam int SLOT_AW = $clog2(SLOTS);
	localparam int SLOT_CW = $clog2(SLOTS + 1);
	localparam int IDX_W   = (VAL_CW > SLOT_CW) ? VAL_CW : SLOT_CW;

	localparam logic [10:0] VOTER_MAX = 11'h7FF;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_VOTE  = 2'd0,
		CMD_STAKE = 2'd1,
		CMD_PRUNE = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	// Status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VSCAN,
		ST_VWR,
		ST_ESCAN,
		ST_EDONE,
		ST_UPD,
		ST_PSCAN,
		ST_HSCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [63:0] slot;
		logic [63:0] root_mark;
		logic [47:0] stake;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] voted_stake;
		logic [10:0] slot_voters;
		logic        slot_confirmed;
		logic        slot_finalized;
		logic [63:0] total_stake_out;
		logic [63:0] highest_confirmed;
		logic [63:0] highest_finalized;
	} rsp_t;

	// One validator record.
	typedef struct packed {
		logic [255:0] key;
		logic [47:0]  stake;
		logic [63:0]  last;
	} val_entry_t;

	// One slot record.
	typedef struct packed {
		logic [63:0] number;
		logic [63:0] vote;
		logic [63:0] root;
		logic [10:0] count;
		logic        conf;
		logic        fin;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [VAL_AW-1:0] addr;
		val_entry_t        data;
	} val_wr_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_AW-1:0] addr;
		slot_entry_t        data;
	} slot_wr_t;

endpackage

`default_nettype wire

[hw/rtl/swvt_val_store.sv]
// Validator record memory with one write port and one registered read port.
`default_nettype none

module swvt_val_store import swvt_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [VAL_AW-1:0] rd_addr,
	output val_entry_t        rd_data,
	input  val_wr_t           wr
);

	val_entry_t mem [VALIDATORS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/swvt_slot_store.sv]
// Slot record memory with per-entry valid bits.
`default_nettype none

module swvt_slot_store import swvt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [SLOT_AW-1:0] rd_addr,
	output slot_entry_t        rd_data,
	output logic               rd_valid,
	input  slot_wr_t           wr,
	input  logic               clr_en,
	input  logic [SLOT_AW-1:0] clr_addr
);

	slot_entry_t mem [SLOTS];
	logic [SLOTS-1:0] valid_q;

	// Write port; a written entry becomes valid.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read of record and valid bit.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data  <= mem[rd_addr];
			rd_valid <= valid_q[rd_addr];
		end
	end

	// Valid bits are set on write and cleared by pruning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/swvt_acc.sv]
// Saturating stake accumulator with the exact two-thirds threshold test.
`default_nettype none

module swvt_acc import swvt_pkg::*; (
	input  logic [63:0] acc,
	input  logic [47:0] add,
	input  logic [63:0] total,
	output logic [63:0] sum,
	output logic        reached
);

	logic [64:0] wide;
	logic [65:0] part3;
	logic [65:0] whole2;

	// Saturating add.
	assign wide = {1'b0, acc} + {17'd0, add};
	assign sum  = wide[64] ? '1 : wide[63:0];

	// sum * 3 >= total * 2 without wrap.
	assign part3   = {2'b00, sum} + {1'b0, sum, 1'b0};
	assign whole2  = {1'b0, total, 1'b0};
	assign reached = (part3 >= whole2);

endmodule

`default_nettype wire

[hw/rtl/stake_weighted_vote_tally.sv]
// Top level of the stake-weighted vote tally: sequencer and datapath.
//
//  channel  direction  signals
//  req      in         req_valid, req_ready, req (req_t)
//  rsp      out        rsp_valid, rsp_ready, rsp (rsp_t)
//  cfg      in         cfg_we, cfg_wdata (prune enable)
//
// One request at a time; req_ready is high only while the sequencer is idle.
// A vote walks the known validators one per cycle, then scans the 64 slot
// entries once for the vote slot and once for a nonzero root, then scans
// them again for the highest flags.
// Reset clears the validator count, total stake and slot valid bits at once.
// The response waits in its output register while rsp_ready is low.
`default_nettype none
`include "stake_weighted_vote_tally_defines.svh"

module stake_weighted_vote_tally import swvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	state_t state_q, state_d;
	req_t   req_q;
	logic   en_q;
	logic [VAL_CW-1:0] used_q;
	logic [63:0] sum_q;

	logic [IDX_W-1:0] idx_q, a_s1;
	logic sv_s1;

	logic found_q;
	logic [VAL_AW-1:0] vidx_q;
	val_entry_t vdata_q;
	logic [63:0] prev_q;

	logic ehit_q;
	logic [SLOT_AW-1:0] eidx_q;
	slot_entry_t edata_q;
	logic free_q;
	logic [SLOT_AW-1:0] free_pos_q, low_pos_q;
	logic [63:0] low_q;
	logic root_ph_q;
	logic [63:0] tgt_q;

	logic [1:0]  status_q;
	logic [63:0] qstake_q;
	logic [10:0] qvoters_q;
	logic qconf_q, qfin_q;
	logic [63:0] hc_q, hf_q;

	val_entry_t val_rd;
	val_wr_t val_wr;
	slot_entry_t slot_rd;
	logic slot_rd_valid;
	slot_wr_t slot_wr;
	logic slot_clr_en;

	logic [63:0] acc_in, acc_sum;
	logic acc_hit;
	slot_entry_t upd;

	logic is_scan, issue, scan_end, scan_start, key_hit, slot_hit, val_full;
	logic [IDX_W-1:0] scan_lim;
	logic [255:0] req_key;
	logic [SLOT_AW-1:0] new_pos;

	assign req_key  = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
	assign val_full = (used_q == VAL_CW'(VALIDATORS));

	// Scan control shared by all table walks.
	assign is_scan = (state_q == ST_VSCAN) || (state_q == ST_ESCAN) ||
		(state_q == ST_PSCAN) || (state_q == ST_HSCAN);
	assign scan_lim = (state_q == ST_VSCAN) ? IDX_W'(used_q) : IDX_W'(SLOTS);
	assign issue    = is_scan && (idx_q < scan_lim);
	assign scan_end = !issue && !sv_s1;
	assign scan_start = (state_d != state_q) && ((state_d == ST_VSCAN) ||
		(state_d == ST_ESCAN) || (state_d == ST_PSCAN) || (state_d == ST_HSCAN));
	assign key_hit  = sv_s1 && (val_rd.key == req_key);
	assign slot_hit = sv_s1 && slot_rd_valid && (slot_rd.number == tgt_q);
	assign new_pos  = free_q ? free_pos_q : low_pos_q;

	// Memories.
	swvt_val_store u_val (
		.clk     (clk),
		.rd_en   (issue && (state_q == ST_VSCAN)),
		.rd_addr (idx_q[VAL_AW-1:0]),
		.rd_data (val_rd),
		.wr      (val_wr)
	);

	swvt_slot_store u_slot (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (issue && (state_q != ST_VSCAN)),
		.rd_addr  (idx_q[SLOT_AW-1:0]),
		.rd_data  (slot_rd),
		.rd_valid (slot_rd_valid),
		.wr       (slot_wr),
		.clr_en   (slot_clr_en),
		.clr_addr (a_s1[SLOT_AW-1:0])
	);

	// Shared accumulate and threshold unit.
	assign acc_in = root_ph_q ? edata_q.root : edata_q.vote;

	swvt_acc u_acc (
		.acc     (acc_in),
		.add     (req_q.stake),
		.total   (sum_q),
		.sum     (acc_sum),
		.reached (acc_hit)
	);

	// Updated slot record for the vote or the root phase.
	always_comb begin
		upd = edata_q;
		if (root_ph_q) begin
			upd.root = acc_sum;
			upd.fin  = edata_q.fin | acc_hit;
		end else begin
			upd.vote  = acc_sum;
			upd.count = (edata_q.count != VOTER_MAX) ? edata_q.count + 11'd1 : edata_q.count;
			upd.conf  = edata_q.conf | acc_hit;
		end
	end

	// Next state and memory strobes.
	always_comb begin
		state_d = state_q;
		val_wr = '0;
		val_wr.addr = found_q ? vidx_q : used_q[VAL_AW-1:0];
		val_wr.data.key   = req_key;
		val_wr.data.stake = req_q.stake;
		val_wr.data.last  = (cmd_t'(req_q.cmd) == CMD_VOTE) ? req_q.slot : vdata_q.last;
		slot_wr = '0;
		slot_wr.addr = eidx_q;
		slot_wr.data = upd;
		slot_clr_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (cmd_t'(req.cmd))
						CMD_VOTE, CMD_STAKE: state_d = ST_VSCAN;
						CMD_PRUNE:           state_d = en_q ? ST_PSCAN : ST_HSCAN;
						CMD_QUERY:           state_d = ST_ESCAN;
						default:             state_d = ST_HSCAN;
					endcase
				end
			end
			ST_VSCAN: begin
				if (key_hit || scan_end) begin
					state_d = ST_VWR;
				end
			end
			ST_VWR: begin
				if (cmd_t'(req_q.cmd) == CMD_VOTE) begin
					if (!found_q && val_full) begin
						state_d = ST_HSCAN;
					end else begin
						val_wr.en = 1'b1;
						state_d = ST_ESCAN;
					end
				end else begin
					val_wr.en = found_q;
					state_d = ST_HSCAN;
				end
			end
			ST_ESCAN: begin
				if (slot_hit || scan_end) begin
					state_d = ST_EDONE;
				end
			end
			ST_EDONE: begin
				if (cmd_t'(req_q.cmd) == CMD_QUERY) begin
					state_d = ST_HSCAN;
				end else begin
					if (!ehit_q) begin
						slot_wr.en = 1'b1;
						slot_wr.addr = new_pos;
						slot_wr.data = '{number: tgt_q, vote: '0, root: '0, count: '0,
							conf: 1'b0, fin: 1'b0};
					end
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (root_ph_q) begin
					slot_wr.en = 1'b1;
					state_d = ST_HSCAN;
				end else begin
					slot_wr.en = (prev_q != req_q.slot);
					state_d = (req_q.root_mark != 64'd0) ? ST_ESCAN : ST_HSCAN;
				end
			end
			ST_PSCAN: begin
				slot_clr_en = sv_s1 && slot_rd_valid && (slot_rd.number < req_q.root_mark);
				if (scan_end) begin
					state_d = ST_HSCAN;
				end
			end
			ST_HSCAN: begin
				if (scan_end) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: validator count, total stake, config, read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			sum_q  <= '0;
			en_q   <= 1'b1;
			sv_s1  <= 1'b0;
		end else begin
			sv_s1 <= issue;
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (state_q == ST_VWR && val_wr.en) begin
				if (found_q) begin
					sum_q <= sum_q - {16'd0, vdata_q.stake} + {16'd0, req_q.stake};
				end else begin
					sum_q  <= sum_q + {16'd0, req_q.stake};
					used_q <= used_q + VAL_CW'(1);
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		a_s1 <= idx_q;
		if (scan_start) begin
			idx_q      <= '0;
			free_q     <= 1'b0;
			free_pos_q <= '0;
			low_q      <= '1;
			low_pos_q  <= '0;
			ehit_q     <= 1'b0;
			hc_q       <= '0;
			hf_q       <= '0;
		end else if (issue) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q     <= req;
					status_q  <= STATUS_OK;
					qstake_q  <= '0;
					qvoters_q <= '0;
					qconf_q   <= 1'b0;
					qfin_q    <= 1'b0;
					root_ph_q <= 1'b0;
					tgt_q     <= req.slot;
					found_q   <= 1'b0;
				end
			end
			ST_VSCAN: begin
				if (key_hit) begin
					found_q <= 1'b1;
					vidx_q  <= a_s1[VAL_AW-1:0];
					vdata_q <= val_rd;
				end
			end
			ST_VWR: begin
				prev_q <= found_q ? vdata_q.last : 64'd0;
				if (cmd_t'(req_q.cmd) == CMD_VOTE) begin
					if (!found_q && val_full) begin
						status_q <= STATUS_FULL;
					end
				end else if (!found_q) begin
					status_q <= STATUS_NOTFOUND;
				end
			end
			ST_ESCAN: begin
				if (sv_s1) begin
					if (slot_hit) begin
						ehit_q  <= 1'b1;
						eidx_q  <= a_s1[SLOT_AW-1:0];
						edata_q <= slot_rd;
					end
					if (!slot_rd_valid && !free_q) begin
						free_q     <= 1'b1;
						free_pos_q <= a_s1[SLOT_AW-1:0];
					end
					if (slot_rd.number < low_q) begin
						low_q     <= slot_rd.number;
						low_pos_q <= a_s1[SLOT_AW-1:0];
					end
				end
			end
			ST_EDONE: begin
				if (cmd_t'(req_q.cmd) == CMD_QUERY) begin
					if (ehit_q) begin
						qstake_q  <= edata_q.vote;
						qvoters_q <= edata_q.count;
						qconf_q   <= edata_q.conf;
						qfin_q    <= edata_q.fin;
					end else begin
						status_q <= STATUS_NOTFOUND;
					end
				end else if (!ehit_q) begin
					eidx_q  <= new_pos;
					edata_q <= '{number: tgt_q, vote: '0, root: '0, count: '0,
						conf: 1'b0, fin: 1'b0};
				end
			end
			ST_UPD: begin
				if (!root_ph_q) begin
					root_ph_q <= 1'b1;
					tgt_q     <= req_q.root_mark;
				end
			end
			ST_HSCAN: begin
				if (sv_s1 && slot_rd_valid) begin
					if (slot_rd.conf && slot_rd.number > hc_q) begin
						hc_q <= slot_rd.number;
					end
					if (slot_rd.fin && slot_rd.number > hf_q) begin
						hf_q <= slot_rd.number;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Handshake and response.
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);

	always_comb begin
		rsp.status            = status_q;
		rsp.voted_stake       = qstake_q;
		rsp.slot_voters       = qvoters_q;
		rsp.slot_confirmed    = qconf_q;
		rsp.slot_finalized    = qfin_q;
		rsp.total_stake_out   = sum_q;
		rsp.highest_confirmed = hc_q;
		rsp.highest_finalized = hf_q;
	end

	// Checks.
	`SWVT_ASSERT_IMP(a_rsp_busy, rsp_valid, !req_ready, "request taken while response pending")
	`SWVT_ASSERT_IMP(a_used_max, 1'b1, used_q <= VAL_CW'(VALIDATORS), "validator count overflow")
	`SWVT_ASSERT_NXT(a_accept_busy, req_valid && req_ready, !req_ready, "ready after accept")
	`SWVT_ASSERT_NXT(a_used_step, state_q != ST_VWR, $stable(used_q), "count moved outside insert")

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the stake-weighted vote tally.
`default_nettype none

module testbench;
	import swvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NVAL = 1024;
	localparam int NSLOT = 64;
	localparam logic [63:0] U64MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic cfg_wdata;

	stake_weighted_vote_tally dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Predicted state of the tally.
	logic [255:0] tally_key[NVAL];
	logic [47:0] tally_vstake[NVAL];
	logic [63:0] tally_vlast[NVAL];
	int tally_used;
	logic [63:0] tally_total;
	logic ent_valid[NSLOT];
	logic [63:0] ent_num[NSLOT];
	logic [63:0] ent_vote[NSLOT];
	logic [63:0] ent_root[NSLOT];
	logic [10:0] ent_count[NSLOT];
	logic ent_conf[NSLOT];
	logic ent_fin[NSLOT];
	logic prune_on;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_rsp;
	int hold_left;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Exact check of part*3 >= whole*2.
	function automatic bit reaches_two_thirds(logic [63:0] part, logic [63:0] whole);
		logic [65:0] a;
		logic [65:0] b;
		a = 66'(part) * 66'd3;
		b = 66'(whole) * 66'd2;
		return a >= b;
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = 65'(a) + 65'(b);
		return s[64] ? U64MAX : s[63:0];
	endfunction

	function automatic int lookup_slot(logic [63:0] s);
		for (int i = 0; i < NSLOT; i++)
			if (ent_valid[i] && ent_num[i] == s) return i;
		return -1;
	endfunction

	function automatic int open_slot(logic [63:0] s);
		int pos;
		logic [63:0] low;
		pos = lookup_slot(s);
		if (pos >= 0) return pos;
		for (int i = 0; i < NSLOT; i++)
			if (!ent_valid[i]) begin
				pos = i;
				break;
			end
		if (pos < 0) begin
			pos = 0;
			low = U64MAX;
			for (int i = 0; i < NSLOT; i++)
				if (ent_num[i] < low) begin
					low = ent_num[i];
					pos = i;
				end
		end
		ent_valid[pos] = 1;
		ent_num[pos] = s;
		ent_vote[pos] = 0;
		ent_root[pos] = 0;
		ent_count[pos] = 0;
		ent_conf[pos] = 0;
		ent_fin[pos] = 0;
		return pos;
	endfunction

	function automatic int lookup_validator(logic [255:0] k);
		for (int i = 0; i < tally_used; i++)
			if (tally_key[i] == k) return i;
		return -1;
	endfunction

	// Apply one request to the predicted state and return the response.
	function automatic rsp_t tally_apply(req_t r);
		rsp_t o;
		logic [255:0] k;
		logic [63:0] prev;
		int v;
		int e;
		o = '0;
		k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
		case (cmd_t'(r.cmd))
			CMD_VOTE: begin
				v = lookup_validator(k);
				if (v < 0 && tally_used >= NVAL) begin
					o.status = STATUS_FULL;
				end else begin
					if (v < 0) begin
						v = tally_used++;
						tally_key[v] = k;
						tally_vstake[v] = r.stake;
						tally_vlast[v] = 0;
						tally_total += 64'(r.stake);
					end
					prev = tally_vlast[v];
					tally_vlast[v] = r.slot;
					tally_total = tally_total - 64'(tally_vstake[v]) + 64'(r.stake);
					tally_vstake[v] = r.stake;
					e = open_slot(r.slot);
					if (prev != r.slot) begin
						ent_vote[e] = add_sat(ent_vote[e], 64'(r.stake));
						if (ent_count[e] < VOTER_MAX) ent_count[e]++;
						if (!ent_conf[e] && reaches_two_thirds(ent_vote[e], tally_total))
							ent_conf[e] = 1;
					end
					if (r.root_mark != 0) begin
						e = open_slot(r.root_mark);
						ent_root[e] = add_sat(ent_root[e], 64'(r.stake));
						if (!ent_fin[e] && reaches_two_thirds(ent_root[e], tally_total))
							ent_fin[e] = 1;
					end
				end
			end
			CMD_STAKE: begin
				v = lookup_validator(k);
				if (v < 0) begin
					o.status = STATUS_NOTFOUND;
				end else begin
					tally_total = tally_total - 64'(tally_vstake[v]) + 64'(r.stake);
					tally_vstake[v] = r.stake;
				end
			end
			CMD_PRUNE: begin
				if (prune_on)
					for (int i = 0; i < NSLOT; i++)
						if (ent_valid[i] && ent_num[i] < r.root_mark) ent_valid[i] = 0;
			end
			default: begin
				e = lookup_slot(r.slot);
				if (e < 0) begin
					o.status = STATUS_NOTFOUND;
				end else begin
					o.voted_stake = ent_vote[e];
					o.slot_voters = ent_count[e];
					o.slot_confirmed = ent_conf[e];
					o.slot_finalized = ent_fin[e];
				end
			end
		endcase
		for (int i = 0; i < NSLOT; i++) begin
			if (!ent_valid[i]) continue;
			if (ent_conf[i] && ent_num[i] > o.highest_confirmed) o.highest_confirmed = ent_num[i];
			if (ent_fin[i] && ent_num[i] > o.highest_finalized) o.highest_finalized = ent_num[i];
		end
		o.total_stake_out = tally_total;
		return o;
	endfunction

	function automatic req_t make_request(cmd_t c, logic [255:0] k, logic [63:0] s,
			logic [63:0] rt, logic [47:0] st);
		req_t r;
		r.cmd = c;
		{r.key_word3, r.key_word2, r.key_word1, r.key_word0} = k;
		r.slot = s;
		r.root_mark = rt;
		r.stake = st;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [255:0] rand_key();
		return {rand64(), rand64(), rand64(), rand64()};
	endfunction

	// Keys from a small pool so that votes hit known validators.
	function automatic logic [255:0] pool_key(int i);
		return {64'hA5A5_0000_0000_0000 ^ 64'(i), 64'(i) * 64'h9E37_79B9, 64'(i), ~64'(i)};
	endfunction

	// Driver: presents queued requests, keeps valid up until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 0;
			req <= '0;
		end else if (!req_valid || req_ready) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1;
				req <= pending_reqs.pop_front();
			end else begin
				req_valid <= 0;
			end
		end
	end

	// Predict on acceptance.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) expected_rsps.push_back(tally_apply(req));
	end

	// Receiver stalls, with an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 0;
			hold_left <= 0;
		end else if (hold_rsp && hold_left == 0) begin
			hold_left <= 4000;
			rsp_ready <= 0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 0;
		end else begin
			hold_left <= 0;
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: compare each response against the oldest expectation.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: response with nothing expected, actual %p", $realtime, rsp);
				errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp.status !== exp_rsp.status ||
						rsp.voted_stake !== exp_rsp.voted_stake ||
						rsp.slot_voters !== exp_rsp.slot_voters ||
						rsp.slot_confirmed !== exp_rsp.slot_confirmed ||
						rsp.slot_finalized !== exp_rsp.slot_finalized ||
						rsp.total_stake_out !== exp_rsp.total_stake_out ||
						rsp.highest_confirmed !== exp_rsp.highest_confirmed ||
						rsp.highest_finalized !== exp_rsp.highest_finalized) begin
					$display("%0t: mismatch, expected %p, actual %p", $realtime, exp_rsp, rsp);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_pruning(logic v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		prune_on = v;
		cfg_we <= 0;
	endtask

	// Mostly votes from a validator pool over a sliding slot window.
	task automatic queue_random(int n, int base);
		int c;
		logic [63:0] s;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(99);
			s = 64'(base + i / 4 + $urandom_range(6));
			if (c < 60)
				pending_reqs.push_back(make_request(CMD_VOTE, pool_key($urandom_range(40)), s,
					($urandom_range(2) == 0) ? 64'd0 : s - 64'($urandom_range(3)),
					($urandom_range(9) == 0) ? 48'(rand64()) : 48'($urandom_range(1000))));
			else if (c < 70)
				pending_reqs.push_back(make_request(CMD_STAKE,
					($urandom_range(4) == 0) ? rand_key() : pool_key($urandom_range(40)),
					rand64(), rand64(), 48'($urandom_range(1000))));
			else if (c < 75)
				pending_reqs.push_back(make_request(CMD_PRUNE, rand_key(), rand64(),
					s - 64'($urandom_range(20)), 48'(rand64())));
			else if (c < 95)
				pending_reqs.push_back(make_request(CMD_QUERY, rand_key(), s, rand64(),
					48'(rand64())));
			else
				pending_reqs.push_back(make_request(cmd_t'($urandom_range(3)), rand_key(),
					rand64(), rand64(), 48'(rand64())));
		end
	endtask

	initial begin
		errors = 0;
		hold_rsp = 0;
		send_idle_pct = 6;
		recv_idle_pct = 57;
		cfg_we = 0;
		cfg_wdata = 0;
		arst_n = 0;
		tally_used = 0;
		tally_total = 0;
		prune_on = 1;
		for (int i = 0; i < NSLOT; i++) ent_valid[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every command and the special cases.
		pending_reqs.push_back(make_request(CMD_QUERY, '0, 64'd5, 64'd0, 48'd0));
		pending_reqs.push_back(make_request(CMD_STAKE, '1, 64'd0, 64'd0, 48'd7));
		pending_reqs.push_back(make_request(CMD_VOTE, '1, U64MAX, U64MAX, 48'hFFFF_FFFF_FFFF));
		pending_reqs.push_back(make_request(CMD_VOTE, '0, 64'd10, 64'd10, 48'd0));
		pending_reqs.push_back(make_request(CMD_VOTE, pool_key(1), 64'd10, 64'd8, 48'd100));
		pending_reqs.push_back(make_request(CMD_VOTE, pool_key(1), 64'd10, 64'd9, 48'd100));
		pending_reqs.push_back(make_request(CMD_QUERY, '0, 64'd10, 64'd0, 48'd0));
		pending_reqs.push_back(make_request(CMD_QUERY, '0, U64MAX, 64'd0, 48'd0));
		pending_reqs.push_back(make_request(CMD_STAKE, '1, 64'd0, 64'd0, 48'd0));
		pending_reqs.push_back(make_request(CMD_VOTE, '1, U64MAX, U64MAX, 48'hFFFF_FFFF_FFFF));
		pending_reqs.push_back(make_request(CMD_VOTE, pool_key(2), U64MAX, U64MAX,
			48'hFFFF_FFFF_FFFF));
		pending_reqs.push_back(make_request(CMD_QUERY, '0, U64MAX, 64'd0, 48'd0));
		// Fill the slot table to force eviction, root evicting its vote slot.
		for (int i = 0; i < 32; i++)
			pending_reqs.push_back(make_request(CMD_VOTE, pool_key(3), 64'(100 + 4 * i),
				64'(101 + 4 * i), 48'd5));
		pending_reqs.push_back(make_request(CMD_VOTE, pool_key(4), 64'd3, 64'd4, 48'd5));
		pending_reqs.push_back(make_request(CMD_PRUNE, '0, 64'd0, 64'd120, 48'd0));
		pending_reqs.push_back(make_request(CMD_QUERY, '0, 64'd100, 64'd0, 48'd0));
		set_pruning(0);
		pending_reqs.push_back(make_request(CMD_PRUNE, '0, 64'd0, U64MAX, 48'd0));
		pending_reqs.push_back(make_request(CMD_QUERY, '0, 64'd160, 64'd0, 48'd0));
		queue_random(135, 200);

		// Long receiver hold-off while requests keep coming.
		drain();
		send_idle_pct = 0;
		queue_random(20, 400);
		hold_rsp = 1;
		wait (hold_left > 0);
		hold_rsp = 0;

		set_pruning(1);
		send_idle_pct = 57;
		recv_idle_pct = 6;
		queue_random(170, 600);
		set_pruning(0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(80, 900);
		set_pruning(1);
		queue_random(80, 1200);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
